[design/alu8f_pkg.sv]
// ----------------------------------------------------------------------------
// alu8f_pkg
// Shared types for the 8-bit ALU with flags: operation codes and stage records.
// ----------------------------------------------------------------------------
package alu8f_pkg;

	typedef enum logic [4:0] {
		KIND_ADD  = 5'd0,
		KIND_ADC  = 5'd1,
		KIND_SUB  = 5'd2,
		KIND_SBC  = 5'd3,
		KIND_AND  = 5'd4,
		KIND_XOR  = 5'd5,
		KIND_OR   = 5'd6,
		KIND_CP   = 5'd7,
		KIND_INC  = 5'd8,
		KIND_DEC  = 5'd9,
		KIND_DAA  = 5'd10,
		KIND_CPL  = 5'd11,
		KIND_RLCA = 5'd12,
		KIND_RLA  = 5'd13,
		KIND_RRCA = 5'd14,
		KIND_RRA  = 5'd15,
		KIND_RLC  = 5'd16,
		KIND_RL   = 5'd17,
		KIND_RRC  = 5'd18,
		KIND_RR   = 5'd19,
		KIND_SLA  = 5'd20,
		KIND_SWAP = 5'd21,
		KIND_SRA  = 5'd22,
		KIND_SRL  = 5'd23,
		KIND_BIT  = 5'd24,
		KIND_SET  = 5'd25,
		KIND_RES  = 5'd26,
		KIND_CCF  = 5'd27,
		KIND_SCF  = 5'd28
	} kind_t;

	localparam logic [3:0] DAA_LOW_LIMIT  = 4'h9;
	localparam logic [8:0] DAA_HIGH_LIMIT = 9'h09f;
	localparam logic [7:0] DAA_LOW_ADJ    = 8'h06;
	localparam logic [7:0] DAA_HIGH_ADJ   = 8'h60;

	// One accepted operation.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] acc;
		logic [7:0] operand;
		logic [2:0] bit_index;
		logic       z;
		logic       n;
		logic       h;
		logic       c;
		logic       s;
		logic       v;
	} in_item_t;

	// Execute stage record: result and flags, with zero and decimal adjust pending.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] res;
		logic [8:0] daa_t1;
		logic       zsel;
		logic       wr;
		logic       z;
		logic       n;
		logic       h;
		logic       c;
		logic       s;
		logic       v;
	} ex_item_t;

	// Finished result.
	typedef struct packed {
		logic [7:0] res;
		logic       wr;
		logic       z;
		logic       n;
		logic       h;
		logic       c;
		logic       s;
		logic       v;
	} out_item_t;

endpackage

[design/alu8f_exec.sv]
// ----------------------------------------------------------------------------
// alu8f_exec
// Execute stage: adders, logic ops, shifts, bit ops and first decimal adjust step.
// ----------------------------------------------------------------------------
module alu8f_exec import alu8f_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_item,
	output logic     in_ready,
	output logic     out_valid,
	output ex_item_t out_item,
	input  logic     out_ready
);

	logic       valid_s2;
	ex_item_t   ex_s2;
	ex_item_t   ex_d;
	logic       ci;
	logic       is_sub;
	logic [8:0] sum9;
	logic [4:0] lo5;
	logic [7:0] inc_r;
	logic [7:0] dec_r;
	logic [7:0] mask;
	logic       daa_lo;

	assign ci = ((in_item.kind == KIND_ADC) || (in_item.kind == KIND_SBC)) ? in_item.c : 1'b0;
	assign is_sub = (in_item.kind == KIND_SUB) || (in_item.kind == KIND_SBC) ||
		(in_item.kind == KIND_CP);
	assign sum9 = is_sub ?
		({1'b0, in_item.acc} - {1'b0, in_item.operand} - {8'd0, ci}) :
		({1'b0, in_item.acc} + {1'b0, in_item.operand} + {8'd0, ci});
	assign lo5 = is_sub ?
		({1'b0, in_item.acc[3:0]} - {1'b0, in_item.operand[3:0]} - {4'd0, ci}) :
		({1'b0, in_item.acc[3:0]} + {1'b0, in_item.operand[3:0]} + {4'd0, ci});
	assign inc_r = in_item.operand + 8'd1;
	assign dec_r = in_item.operand - 8'd1;
	assign mask  = 8'b1 << in_item.bit_index;
	assign daa_lo = in_item.h || (in_item.acc[3:0] > DAA_LOW_LIMIT);

	always_comb begin
		ex_d        = '0;
		ex_d.kind   = in_item.kind;
		ex_d.res    = in_item.acc;
		ex_d.wr     = 1'b1;
		ex_d.zsel   = 1'b0;
		ex_d.z      = in_item.z;
		ex_d.n      = in_item.n;
		ex_d.h      = in_item.h;
		ex_d.c      = in_item.c;
		ex_d.s      = in_item.s;
		ex_d.v      = in_item.v;
		// First decimal adjust step: low nibble correction.
		if (!in_item.n) begin
			ex_d.daa_t1 = {1'b0, in_item.acc} + {1'b0, (daa_lo ? DAA_LOW_ADJ : 8'd0)};
		end else begin
			ex_d.daa_t1 = {1'b0, in_item.acc - (in_item.h ? DAA_LOW_ADJ : 8'd0)};
		end
		case (in_item.kind)
			KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBC, KIND_CP: begin
				ex_d.res  = sum9[7:0];
				ex_d.zsel = 1'b1;
				ex_d.n    = is_sub;
				ex_d.h    = lo5[4];
				ex_d.c    = sum9[8];
				if (in_item.kind == KIND_CP) begin
					ex_d.wr = 1'b0;
					ex_d.s  = sum9[7];
					ex_d.v  = (in_item.acc[7] ^ in_item.operand[7]) &
						(in_item.acc[7] ^ sum9[7]);
				end
			end
			KIND_AND: begin
				ex_d.res = in_item.acc & in_item.operand;
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b1; ex_d.c = 1'b0;
			end
			KIND_XOR: begin
				ex_d.res = in_item.acc ^ in_item.operand;
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0; ex_d.c = 1'b0;
			end
			KIND_OR: begin
				ex_d.res = in_item.acc | in_item.operand;
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0; ex_d.c = 1'b0;
			end
			KIND_INC: begin
				ex_d.res = inc_r;
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = (inc_r[3:0] == 4'h0);
			end
			KIND_DEC: begin
				ex_d.res = dec_r;
				ex_d.zsel = 1'b1; ex_d.n = 1'b1; ex_d.h = (dec_r[3:0] == 4'hf);
			end
			KIND_DAA: begin
				ex_d.zsel = 1'b1; ex_d.h = 1'b0;
			end
			KIND_CPL: begin
				ex_d.res = ~in_item.acc; ex_d.n = 1'b1; ex_d.h = 1'b1;
			end
			KIND_RLCA: begin
				ex_d.res = {in_item.acc[6:0], in_item.acc[7]}; ex_d.c = in_item.acc[7];
				ex_d.z = 1'b0; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_RLA: begin
				ex_d.res = {in_item.acc[6:0], in_item.c}; ex_d.c = in_item.acc[7];
				ex_d.z = 1'b0; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_RRCA: begin
				ex_d.res = {in_item.acc[0], in_item.acc[7:1]}; ex_d.c = in_item.acc[0];
				ex_d.z = 1'b0; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_RRA: begin
				ex_d.res = {in_item.c, in_item.acc[7:1]}; ex_d.c = in_item.acc[0];
				ex_d.z = 1'b0; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_RLC: begin
				ex_d.res = {in_item.operand[6:0], in_item.operand[7]};
				ex_d.c = in_item.operand[7];
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_RL: begin
				ex_d.res = {in_item.operand[6:0], in_item.c}; ex_d.c = in_item.operand[7];
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_RRC: begin
				ex_d.res = {in_item.operand[0], in_item.operand[7:1]};
				ex_d.c = in_item.operand[0];
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_RR: begin
				ex_d.res = {in_item.c, in_item.operand[7:1]}; ex_d.c = in_item.operand[0];
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_SLA: begin
				ex_d.res = {in_item.operand[6:0], 1'b0}; ex_d.c = in_item.operand[7];
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_SWAP: begin
				ex_d.res = {in_item.operand[3:0], in_item.operand[7:4]}; ex_d.c = 1'b0;
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_SRA: begin
				ex_d.res = {in_item.operand[7], in_item.operand[7:1]};
				ex_d.c = in_item.operand[0];
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_SRL: begin
				ex_d.res = {1'b0, in_item.operand[7:1]}; ex_d.c = in_item.operand[0];
				ex_d.zsel = 1'b1; ex_d.n = 1'b0; ex_d.h = 1'b0;
			end
			KIND_BIT: begin
				ex_d.res = in_item.operand; ex_d.wr = 1'b0;
				ex_d.z = ~|(in_item.operand & mask); ex_d.n = 1'b0; ex_d.h = 1'b1;
			end
			KIND_SET: begin
				ex_d.res = in_item.operand | mask;
			end
			KIND_RES: begin
				ex_d.res = in_item.operand & ~mask;
			end
			KIND_CCF: begin
				ex_d.wr = 1'b0; ex_d.n = 1'b0; ex_d.h = 1'b0; ex_d.c = ~in_item.c;
			end
			KIND_SCF: begin
				ex_d.wr = 1'b0; ex_d.n = 1'b0; ex_d.h = 1'b0; ex_d.c = 1'b1;
			end
			default: begin
				ex_d.wr = 1'b0;
			end
		endcase
	end

	// Advance when the stage is empty or its item leaves this cycle.
	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ex_s2 <= ex_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = ex_s2;

endmodule

[design/alu8f_wb.sv]
// ----------------------------------------------------------------------------
// alu8f_wb
// Final stage: second decimal adjust step, zero flag and output register.
// ----------------------------------------------------------------------------
module alu8f_wb import alu8f_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  ex_item_t  in_item,
	output logic      in_ready,
	output logic      out_valid,
	output out_item_t out_item,
	input  logic      out_ready
);

	logic       valid_s3;
	out_item_t  out_s3;
	out_item_t  out_d;
	logic [8:0] daa_t2;
	logic [7:0] res;

	always_comb begin
		daa_t2 = '0;
		res    = in_item.res;
		out_d  = '0;
		out_d.c = in_item.c;
		if (in_item.kind == KIND_DAA) begin
			if (!in_item.n) begin
				daa_t2 = in_item.daa_t1 + {1'b0,
					((in_item.c || (in_item.daa_t1 > DAA_HIGH_LIMIT)) ? DAA_HIGH_ADJ : 8'd0)};
				res     = daa_t2[7:0];
				out_d.c = in_item.c | daa_t2[8];
			end else begin
				res = in_item.daa_t1[7:0] - (in_item.c ? DAA_HIGH_ADJ : 8'd0);
			end
		end
		out_d.res = res;
		out_d.wr  = in_item.wr;
		out_d.z   = in_item.zsel ? (res == 8'd0) : in_item.z;
		out_d.n   = in_item.n;
		out_d.h   = in_item.h;
		out_d.s   = in_item.s;
		out_d.v   = in_item.v;
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_s3 <= out_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = out_s3;

endmodule

[design/alu_8bit_with_flags_core.sv]
// ----------------------------------------------------------------------------
// alu_8bit_with_flags_core
// 8-bit ALU with flags and decimal adjust, three-stage stream pipeline.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Carries
// s_axis    in         one operation: kind, acc, operand, bit index, flags
// m_axis    out        one result: byte, write-back mark, new flags
//
// Each item passes three register stages, from the input register through
// execute to the output register; while m_axis does not stall, a new item can
// enter every cycle. Stage one registers the item, stage two runs
// the adders, logic ops, shifts and low-nibble decimal adjust, stage three
// finishes the decimal adjust and the zero flag. Reset clears the stage valid
// bits only. Each stage holds its item while the stage after it is full and
// not draining, so a stall on m_axis backs up without dropping or repeating.
//
module alu_8bit_with_flags_core import alu8f_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] acc, [15:8] operand, [18:16] bit_index, [19] zero_in,
	// [20] subtract_in, [21] half_in, [22] carry_in, [23] sign_in,
	// [24] overflow_in, [31:25] zero
	input  logic [31:0] s_axis_tdata,
	// [4:0] kind
	input  logic [4:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] result, [8] zero_flag, [9] subtract_flag, [10] half_flag,
	// [11] carry_flag, [12] sign_flag, [13] overflow_flag, [15:14] zero
	output logic [15:0] m_axis_tdata,
	// [0] write-back mark: the result byte is to be written
	output logic [0:0]  m_axis_tuser
);

	logic      valid_s1;
	in_item_t  item_s1;
	in_item_t  item_d;
	logic      ex_ready;
	logic      ex_valid;
	ex_item_t  ex_item;
	logic      wb_ready;
	out_item_t out_item;

	// Unpack the stream item into its fields.
	always_comb begin
		item_d.kind      = kind_t'(s_axis_tuser);
		item_d.acc       = s_axis_tdata[7:0];
		item_d.operand   = s_axis_tdata[15:8];
		item_d.bit_index = s_axis_tdata[18:16];
		item_d.z         = s_axis_tdata[19];
		item_d.n         = s_axis_tdata[20];
		item_d.h         = s_axis_tdata[21];
		item_d.c         = s_axis_tdata[22];
		item_d.s         = s_axis_tdata[23];
		item_d.v         = s_axis_tdata[24];
	end

	// Input register: take a new item when empty or when the held one moves on.
	assign s_axis_tready = !valid_s1 || ex_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_d;
		end
	end

	alu8f_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_item   (item_s1),
		.in_ready  (ex_ready),
		.out_valid (ex_valid),
		.out_item  (ex_item),
		.out_ready (wb_ready)
	);

	alu8f_wb u_wb (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ex_valid),
		.in_item   (ex_item),
		.in_ready  (wb_ready),
		.out_valid (m_axis_tvalid),
		.out_item  (out_item),
		.out_ready (m_axis_tready)
	);

	// Pack the result item.
	assign m_axis_tdata = {2'b00, out_item.v, out_item.s, out_item.c, out_item.h,
		out_item.n, out_item.z, out_item.res};
	assign m_axis_tuser = out_item.wr;

endmodule
